// ===== rtl/wmf_pkg.sv =====
// shared types and constants of the window median filter
`default_nettype none
package wmf_pkg;

  localparam int PIX_W    = 8;
  localparam int CHANNELS = 3;
  localparam int COORD_W  = 10;
  localparam int CFG_W    = 9;
  localparam int CFGIDX_W = 2;

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_HALF_W = 2'd2,
    CFG_HALF_H = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_GATHER = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_START  = 5'b01000,
    S_SELECT = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic start;
  } sel_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/wmf_if.sv =====
// stream interfaces for pixel items and median items
`default_nettype none
interface wmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_zero;
  logic [7:0] chan_one;
  logic [7:0] chan_two;
  modport source (output valid, chan_zero, chan_one, chan_two, input ready);
  modport sink (input valid, chan_zero, chan_one, chan_two, output ready);
endinterface

interface wmf_med_if;
  logic       valid;
  logic       ready;
  logic [7:0] med_zero;
  logic [7:0] med_one;
  logic [7:0] med_two;
  logic       frame_end;
  modport source (output valid, med_zero, med_one, med_two, frame_end, input ready);
  modport sink (input valid, med_zero, med_one, med_two, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/window_median_filter_core.sv =====
// top level of the window median filter: scan, row store, window gather
//
//  channel | ports     | direction | content
//  --------+-----------+-----------+---------------------------------------
//  pixel   | in_pix    | sink      | chan_zero, chan_one, chan_two
//  median  | out_med   | source    | med_zero, med_one, med_two, frame_end
//  config  | cfg_*     | write     | cfg_index selects, cfg_data 9 bits
//
// an item with no result leaves the block ready for the next item; one with a result
// is gathered from the in-frame window (up to 49 pixels) through the single ram
// read port, one neighbour a cycle, then ranked in the 8 bit-serial rank steps and
// loaded into the output register
// reset is synchronous active low, no clearing pass over the row store
// a new item is taken while the previous result still waits on out_med.ready
`default_nettype none
module window_median_filter_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wmf_pix_if.sink                            in_pix,
  wmf_med_if.source                          out_med,
  input  wire logic                          cfg_we,
  input  wire logic [wmf_pkg::CFGIDX_W-1:0]  cfg_index,
  input  wire logic [wmf_pkg::CFG_W-1:0]     cfg_data
);
  import wmf_pkg::*;

  localparam int ROWS   = 2 * MAX_RADIUS + 1;
  localparam int ER     = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
  localparam int WIN    = (2 * ER + 1) * (2 * ER + 1);
  localparam int DEPTH  = ROWS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(ROWS);
  localparam int PXW    = CHANNELS * PIX_W;

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [1:0]       hw_r, hh_r;

  logic [COORD_W-1:0] w_c, h_c, rw_c, rh_c, ext_w, ext_h;
  logic [COORD_W-1:0] scan_row_r, scan_col_r;
  logic [SLOT_W-1:0]  row_slot_r;

  state_t state_r;
  logic   accept;
  logic   in_frame, emit;
  logic [COORD_W-1:0] orow, ocol, y0, y1, x0, x1;
  logic [SLOT_W:0]    slot_tmp;
  logic [SLOT_W-1:0]  y0_slot;

  logic [COORD_W-1:0] gx_r, gy_r, x0_r, x1_r, y1_r;
  logic [SLOT_W-1:0]  gslot_r;
  logic               rd_pend_r, fend_r, last_issue;

  logic [ADDR_W-1:0] waddr, raddr;
  logic [PXW-1:0]    rdata;

  sel_ctrl_t ctrl;
  logic      sel_done;
  logic [CHANNELS-1:0][PIX_W-1:0] sel_res;

  logic            out_v_r;
  logic [PIX_W-1:0] m0_r, m1_r, m2_r;
  logic            fe_r;
  logic            load_out;

  // clamp the frame geometry
  always_comb begin
    if (fw_r == '0) w_c = COORD_W'(1);
    else if (32'(fw_r) > MAX_WIDTH) w_c = COORD_W'(MAX_WIDTH);
    else w_c = COORD_W'(fw_r);
    if (fh_r == '0) h_c = COORD_W'(1);
    else if (32'(fh_r) > MAX_HEIGHT) h_c = COORD_W'(MAX_HEIGHT);
    else h_c = COORD_W'(fh_r);
    rw_c  = (32'(hw_r) > MAX_RADIUS) ? COORD_W'(MAX_RADIUS) : COORD_W'(hw_r);
    rh_c  = (32'(hh_r) > MAX_RADIUS) ? COORD_W'(MAX_RADIUS) : COORD_W'(hh_r);
    ext_w = w_c + rw_c;
    ext_h = h_c + rh_c;
  end

  assign in_pix.ready = (state_r == S_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;

  always_comb begin
    in_frame = (scan_row_r < h_c) && (scan_col_r < w_c);
    emit     = (scan_row_r >= rh_c) && (scan_col_r >= rw_c);
    orow     = scan_row_r - rh_c;
    ocol     = scan_col_r - rw_c;
    y0       = (orow >= rh_c) ? orow - rh_c : '0;
    x0       = (ocol >= rw_c) ? ocol - rw_c : '0;
    y1       = (orow + rh_c > h_c - COORD_W'(1)) ? h_c - COORD_W'(1) : orow + rh_c;
    x1       = (ocol + rw_c > w_c - COORD_W'(1)) ? w_c - COORD_W'(1) : ocol + rw_c;
    // slot of the top window row, stepping back 2*half_h rows modulo the store
    slot_tmp = {1'b0, row_slot_r} + (SLOT_W+1)'(ROWS) - (SLOT_W+1)'(rh_c << 1);
    if (slot_tmp >= (SLOT_W+1)'(ROWS)) slot_tmp = slot_tmp - (SLOT_W+1)'(ROWS);
    y0_slot  = (orow >= rh_c) ? slot_tmp[SLOT_W-1:0] : '0;
  end

  assign waddr = ADDR_W'(row_slot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(scan_col_r);
  assign raddr = ADDR_W'(gslot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(gx_r);
  assign last_issue = (gx_r == x1_r) && (gy_r == y1_r);
  assign load_out   = (state_r == S_SELECT) && sel_done && (!out_v_r || out_med.ready);

  wmf_ram #(.WIDTH(PXW), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (accept && in_frame),
    .waddr   (waddr),
    .wdata   ({in_pix.chan_two, in_pix.chan_one, in_pix.chan_zero}),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  always_comb begin
    ctrl.clear = accept && emit;
    ctrl.push  = rd_pend_r;
    ctrl.start = (state_r == S_START);
  end

  wmf_select #(.WIN(WIN)) u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .push_data (rdata),
    .done_r    (sel_done),
    .res_r     (sel_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= CFG_W'(256);
      fh_r       <= CFG_W'(256);
      hw_r       <= 2'd1;
      hh_r       <= 2'd1;
      scan_row_r <= '0;
      scan_col_r <= '0;
      row_slot_r <= '0;
      state_r    <= S_IDLE;
      rd_pend_r  <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (out_v_r && out_med.ready && !load_out) begin
        out_v_r <= 1'b0;
      end
      rd_pend_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  fw_r <= cfg_data;
          CFG_HEIGHT: fh_r <= cfg_data;
          CFG_HALF_W: hw_r <= cfg_data[1:0];
          CFG_HALF_H: hh_r <= cfg_data[1:0];
          default: ;
        endcase
        scan_row_r <= '0;
        scan_col_r <= '0;
        row_slot_r <= '0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (scan_col_r + COORD_W'(1) >= ext_w) begin
              scan_col_r <= '0;
              if (scan_row_r + COORD_W'(1) >= ext_h) begin
                scan_row_r <= '0;
                row_slot_r <= '0;
              end else begin
                scan_row_r <= scan_row_r + COORD_W'(1);
                row_slot_r <= (row_slot_r == SLOT_W'(ROWS - 1)) ? '0
                                                               : row_slot_r + SLOT_W'(1);
              end
            end else begin
              scan_col_r <= scan_col_r + COORD_W'(1);
            end
            if (emit) begin
              gx_r    <= x0;
              gy_r    <= y0;
              gslot_r <= y0_slot;
              x0_r    <= x0;
              x1_r    <= x1;
              y1_r    <= y1;
              fend_r  <= (scan_row_r == ext_h - COORD_W'(1)) &&
                         (scan_col_r == ext_w - COORD_W'(1));
              state_r <= S_GATHER;
            end
          end
        end
        S_GATHER: begin
          rd_pend_r <= 1'b1;
          if (last_issue) begin
            state_r <= S_DRAIN;
          end else if (gx_r == x1_r) begin
            gx_r    <= x0_r;
            gy_r    <= gy_r + COORD_W'(1);
            gslot_r <= (gslot_r == SLOT_W'(ROWS - 1)) ? '0 : gslot_r + SLOT_W'(1);
          end else begin
            gx_r <= gx_r + COORD_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_SELECT;
        end
        S_SELECT: begin
          if (load_out) begin
            out_v_r <= 1'b1;
            m0_r    <= sel_res[0];
            m1_r    <= sel_res[1];
            m2_r    <= sel_res[2];
            fe_r    <= fend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_med.valid     = out_v_r;
  assign out_med.med_zero  = m0_r;
  assign out_med.med_one   = m1_r;
  assign out_med.med_two   = m2_r;
  assign out_med.frame_end = fe_r;
endmodule
`default_nettype wire

// ===== rtl/wmf_ram.sv =====
// generic single write, single read ram with registered read
`default_nettype none
module wmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1792
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/wmf_select.sv =====
// window shift line and bit-serial rank selection, three channels in parallel
`default_nettype none
module wmf_select #(
  parameter int WIN = 49
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire wmf_pkg::sel_ctrl_t                    ctrl,
  input  wire logic [wmf_pkg::CHANNELS*wmf_pkg::PIX_W-1:0] push_data,
  output logic                                       done_r,
  output logic [wmf_pkg::CHANNELS-1:0][wmf_pkg::PIX_W-1:0] res_r
);
  import wmf_pkg::*;

  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int RANK_W = $clog2(WIN);
  localparam int BIT_W  = $clog2(PIX_W);

  logic [CHANNELS-1:0][PIX_W-1:0] win_r [WIN];
  logic [CNT_W-1:0]               n_r;
  logic [WIN-1:0]                 cand_r [CHANNELS];
  logic [RANK_W-1:0]              rank_r [CHANNELS];
  logic [BIT_W-1:0]               bit_r;
  logic                           busy_r;

  logic [WIN-1:0]   valid_mask;
  logic [WIN-1:0]   msb [CHANNELS];
  logic [WIN-1:0]   zeros [CHANNELS];
  logic [CNT_W-1:0] zcnt [CHANNELS];
  logic             take_zero [CHANNELS];

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      valid_mask[i] = (CNT_W'(i) < n_r);
    end
    for (int k = 0; k < CHANNELS; k++) begin
      for (int i = 0; i < WIN; i++) begin
        msb[k][i] = win_r[i][k][PIX_W-1];
      end
      zeros[k]     = cand_r[k] & ~msb[k];
      zcnt[k]      = CNT_W'($countones(zeros[k]));
      take_zero[k] = zcnt[k] > CNT_W'(rank_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r    <= '0;
      bit_r  <= '0;
    end else begin
      if (ctrl.clear) begin
        n_r <= '0;
      end
      if (ctrl.push) begin
        win_r[0] <= push_data;
        for (int i = 1; i < WIN; i++) begin
          win_r[i] <= win_r[i-1];
        end
        n_r    <= n_r + CNT_W'(1);
        done_r <= 1'b0;
      end
      if (ctrl.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        bit_r  <= '0;
        for (int k = 0; k < CHANNELS; k++) begin
          cand_r[k] <= valid_mask;
          rank_r[k] <= RANK_W'(n_r >> 1);
        end
      end else if (busy_r) begin
        // decide one result bit per channel, msb first
        for (int k = 0; k < CHANNELS; k++) begin
          if (take_zero[k]) begin
            cand_r[k] <= zeros[k];
          end else begin
            cand_r[k] <= cand_r[k] & msb[k];
            rank_r[k] <= rank_r[k] - RANK_W'(zcnt[k]);
          end
          res_r[k] <= {res_r[k][PIX_W-2:0], ~take_zero[k]};
        end
        for (int i = 0; i < WIN; i++) begin
          for (int k = 0; k < CHANNELS; k++) begin
            win_r[i][k] <= {win_r[i][k][PIX_W-2:0], 1'b0};
          end
        end
        bit_r <= bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(PIX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wmf_checker.sv =====
// port-level checks of the window median filter and their binding
`default_nettype none
module wmf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item survives reset");

  // a new result only appears while no item is being taken
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while block was idle");

  // the input stays open while no item is offered
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("input closed with no item taken");
endmodule

bind window_median_filter_core wmf_checker u_wmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_med.valid),
  .out_ready (out_med.ready)
);
`default_nettype wire

// ===== sim/tb_window_median_filter_core.sv =====
// testbench of the window median filter core: random frames checked against a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_window_median_filter_core;
  import wmf_pkg::*;

  localparam int ROWS_KEPT   = 7;
  localparam int LINE_MAX    = 256;
  localparam int WIN_CELLS   = 49;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 80;
  localparam int ITEM_TARGET = 1050;

  typedef struct {
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    logic       fe;
  } median_item_t;

  class median_board;
    logic [23:0]  rows[ROWS_KEPT*LINE_MAX];
    int unsigned  scan_r, scan_c;
    int unsigned  fw, fh, hw, hh;
    median_item_t due[$];
    int           mismatches;
    int           results_seen;
    int           frames_seen;

    function new();
      foreach (rows[i]) rows[i] = '0;
      scan_r = 0; scan_c = 0;
      fw = 256; fh = 256; hw = 1; hh = 1;
      mismatches = 0; results_seen = 0; frames_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [8:0] val);
      case (idx)
        CFG_WIDTH:  fw = 32'(val);
        CFG_HEIGHT: fh = 32'(val);
        CFG_HALF_W: hw = 32'(val[1:0]);
        CFG_HALF_H: hh = 32'(val[1:0]);
        default: ;
      endcase
      scan_r = 0; scan_c = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function logic [7:0] rank_middle(logic [7:0] v[WIN_CELLS], int n);
      logic [7:0] key;
      int j;
      for (int i = 1; i < n; i++) begin
        key = v[i];
        j = i;
        while (j > 0 && v[j-1] > key) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = key;
      end
      return v[n/2];
    endfunction

    function void note_input(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      int unsigned w, h, rw, rh, r, c, orow, ocol, y0, y1, x0, x1;
      logic [7:0] v0[WIN_CELLS], v1[WIN_CELLS], v2[WIN_CELLS];
      logic [23:0] px;
      int n;
      median_item_t e;
      w = clamp(fw, 1, 256); h = clamp(fh, 1, 256);
      rw = clamp(hw, 0, 3); rh = clamp(hh, 0, 3);
      if (scan_r >= h + rh) scan_r = 0;
      if (scan_c >= w + rw) scan_c = 0;
      r = scan_r; c = scan_c;
      if (r < h && c < w) rows[(r % ROWS_KEPT)*LINE_MAX + c] = {c2, c1, c0};
      if (r >= rh && c >= rw) begin
        orow = r - rh; ocol = c - rw;
        y0 = (orow >= rh) ? orow - rh : 0;
        x0 = (ocol >= rw) ? ocol - rw : 0;
        y1 = (orow + rh > h - 1) ? h - 1 : orow + rh;
        x1 = (ocol + rw > w - 1) ? w - 1 : ocol + rw;
        n = 0;
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++) begin
            px = rows[(y % ROWS_KEPT)*LINE_MAX + x];
            v0[n] = px[7:0]; v1[n] = px[15:8]; v2[n] = px[23:16];
            n++;
          end
        e.m0 = rank_middle(v0, n);
        e.m1 = rank_middle(v1, n);
        e.m2 = rank_middle(v2, n);
        e.fe = (r == h + rh - 1 && c == w + rw - 1);
        due.insert(due.size(), e);
      end
      c++;
      if (c >= w + rw) begin
        c = 0;
        r++;
        if (r >= h + rh) r = 0;
      end
      scan_r = r; scan_c = c;
    endfunction

    function void check(logic [7:0] m0, logic [7:0] m1, logic [7:0] m2, logic fe);
      median_item_t e;
      results_seen++;
      if (fe) frames_seen++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median item %0h %0h %0h fe=%0b",
                                       m0, m1, m2, fe);
        return;
      end
      e = due.pop_front();
      if (e.m0 !== m0 || e.m1 !== m1 || e.m2 !== m2 || e.fe !== fe) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median mismatch: expected %0h %0h %0h fe=%0b, got %0h %0h %0h fe=%0b",
                   e.m0, e.m1, e.m2, e.fe, m0, m1, m2, fe);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  wmf_pix_if pix_bus();
  wmf_med_if med_bus();

  window_median_filter_core uut (
    .clk(clk), .rst_n(rst_n), .in_pix(pix_bus), .out_med(med_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  median_board board;
  int accepted = 0;
  int cycles = 0;
  int phases = 0;
  bit held_once = 0;

  initial begin
    pix_bus.valid = 1'b0;
    pix_bus.chan_zero = '0;
    pix_bus.chan_one = '0;
    pix_bus.chan_two = '0;
    med_bus.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle split follows the number of items taken so far
  function int sender_idle_pct();
    return (accepted < 350) ? 34 : (accepted < 700) ? 70 : 0;
  endfunction

  function int receiver_idle_pct();
    return (accepted < 350) ? 70 : (accepted < 700) ? 34 : 0;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) med_bus.ready <= 1'b0;
    else med_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
  end

  always @(posedge clk) begin
    if (rst_n && med_bus.valid && med_bus.ready)
      board.check(med_bus.med_zero, med_bus.med_one, med_bus.med_two, med_bus.frame_end);
  end

  task automatic wait_idle();
    while (board.due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_frame(logic [8:0] w, logic [8:0] h, logic [1:0] rw, logic [1:0] rh);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = CFG_WIDTH;  cfg_data = w;  board.write_reg(CFG_WIDTH, w);
    @(negedge clk);
    cfg_index = CFG_HEIGHT; cfg_data = h;  board.write_reg(CFG_HEIGHT, h);
    @(negedge clk);
    cfg_index = CFG_HALF_W; cfg_data = {7'd0, rw}; board.write_reg(CFG_HALF_W, {7'd0, rw});
    @(negedge clk);
    cfg_index = CFG_HALF_H; cfg_data = {7'd0, rh}; board.write_reg(CFG_HALF_H, {7'd0, rh});
    @(negedge clk);
    cfg_we = 1'b0;
    phases++;
  endtask

  // called at a falling edge, returns at a falling edge with the item taken
  task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    if (!held_once && accepted >= 500) begin
      held_once = 1;
      pix_bus.valid = 1'b0;
      while (board.due.size() != 0) @(negedge clk);
    end
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      pix_bus.valid = 1'b0;
      @(negedge clk);
    end
    pix_bus.valid = 1'b1;
    pix_bus.chan_zero = c0;
    pix_bus.chan_one = c1;
    pix_bus.chan_two = c2;
    do @(posedge clk); while (!pix_bus.ready);
    board.note_input(c0, c1, c2);
    accepted++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_pixel(pick_value(), pick_value(), pick_value());
  endtask

  task automatic end_sending();
    pix_bus.valid = 1'b0;
  endtask

  initial begin
    int w, h, rw, rh, items, big;
    board = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single pixel frame with no window
    set_frame(9'd1, 9'd1, 2'd0, 2'd0);
    send_pixel(8'hff, 8'h00, 8'hff);
    end_sending();
    // widest radius over a tiny frame, nearly all positions are padding
    set_frame(9'd2, 9'd2, 2'd3, 2'd3);
    for (int i = 0; i < 25; i++)
      send_pixel((i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff, 8'(i * 37));
    end_sending();
    // zero sizes saturate to one
    set_frame(9'd0, 9'd0, 2'd2, 2'd1);
    send_random(6);
    end_sending();

    big = 0;
    while (accepted < ITEM_TARGET) begin
      if (big < 3 && accepted >= 250 + big * 300) begin
        case (big)
          0: begin set_frame(9'd511, 9'd1, 2'd0, 2'd0); items = 256; end
          1: begin set_frame(9'd1, 9'd400, 2'd0, 2'd1); items = 257; end
          default: begin set_frame(9'd256, 9'd1, 2'd3, 2'd0); items = 259; end
        endcase
        big++;
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
        rw = $urandom_range(0, 3);
        rh = $urandom_range(0, 3);
        set_frame(9'(w), 9'(h), 2'(rw), 2'(rh));
        items = (w + rw) * (h + rh) * $urandom_range(1, 2);
        // a cut frame now and then, the next write restarts the scan
        if ($urandom_range(0, 7) == 0) items = $urandom_range(1, items);
      end
      if (items > ITEM_TARGET - accepted) items = ITEM_TARGET - accepted;
      send_random(items);
      end_sending();
    end

    while (board.due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d pixel items over %0d frame settings, %0d medians, %0d frame ends",
             accepted, phases, board.results_seen, board.frames_seen);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
